/* rtl/core/bhf_pkg.sv */
// Shared types and constants of the bracket hinge finder.
package bhf_pkg;

  localparam logic [7:0] CHAR_OPEN  = 8'h28;
  localparam logic [7:0] CHAR_CLOSE = 8'h29;

  // Width of a reported bracket position.
  localparam int unsigned POS_W = 12;

  // A hinge spans four brackets; three of them sit on the stack when the
  // fourth arrives, and the stack is spread over that many RAM banks.
  localparam int unsigned HINGE_LEN = 4;
  localparam int unsigned NUM_BANKS = HINGE_LEN - 1;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_UNBALANCED = 2'd1,
    STATUS_OVERFLOW   = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic             hinge_found;
    logic [POS_W-1:0] outer_open_pos;
    logic [POS_W-1:0] inner_open_pos;
    logic [POS_W-1:0] inner_close_pos;
    logic [POS_W-1:0] outer_close_pos;
    logic             string_done;
    status_e          status;
  } out_item_t;

  // One stack entry: bracket kind and its position.
  typedef struct packed {
    logic             is_close;
    logic [POS_W-1:0] pos;
  } entry_t;

  // Commands from the scanner to the stack.
  typedef struct packed {
    logic   push;
    logic   pop3;
    logic   clear;
    entry_t entry;
  } stack_cmd_t;

  // What the stack shows the scanner: the three top entries and fill flags.
  typedef struct packed {
    entry_t top0;
    entry_t top1;
    entry_t top2;
    logic   at_least3;
    logic   full;
    logic   is_empty;
    logic   holds3;
  } stack_view_t;

endpackage

/* rtl/core/bracket_hinge_finder_top.sv */
// Top level of the bracket hinge finder: input register, scanner and result register.
//
// The block scans a dot-bracket string, one character per item, and numbers
// every character from 0. Brackets go onto a stack with their positions; a
// ')' arriving while the top three entries read '(', '(', ')' completes a
// hinge, whose four positions are reported while the three entries are popped.
// The item marked last gives a result with string_done set and a status of ok,
// unbalanced (brackets left on the stack) or overflow (the string ran past
// MAX_LENGTH or the stack past STACK_DEPTH; the scan then ignores characters
// until the last one). Items that neither complete a hinge nor end the string
// give no result. One item is accepted per clock cycle as long as results are
// taken; a result passes from the input register through the scanner into the
// result register. That rate is set by the stack: its three top entries sit in
// registers and the whole stack is spread over three RAM banks, so the
// registered read of one row in each bank always has the three entries below
// the top ready for a pop. A stalled result holds only the scanner; the input
// register still takes one more item. The stack RAM needs no clearing after
// reset, so items are accepted from the first cycle.
module bracket_hinge_finder_top #(
  parameter int unsigned STACK_DEPTH = 1024,
  parameter int unsigned MAX_LENGTH  = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bhf_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bhf_pkg::out_item_t out_item_o
);
  import bhf_pkg::*;

  localparam int unsigned PCW = $clog2(MAX_LENGTH + 1);

  // Input register.
  logic     in_valid_q, in_valid_d;
  in_item_t in_item_q;

  // Scanner state.
  logic [PCW-1:0] pos_q, pos_d;
  logic           ovf_q, ovf_d;

  // Result register.
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q, out_item_d;

  stack_cmd_t  cmd;
  stack_view_t view;

  logic             advance;
  logic             hinge;
  logic             emit;
  logic             empty_after;
  logic [POS_W-1:0] cur_pos;
  logic             is_open;
  logic             is_close;

  // The scanner works on the held item once the result register has room.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_valid_d = in_ready_o ? in_valid_i : in_valid_q;

  assign cur_pos  = POS_W'(pos_q);
  assign is_open  = in_item_q.char_code == CHAR_OPEN;
  assign is_close = in_item_q.char_code == CHAR_CLOSE;

  always_comb begin
    pos_d     = pos_q;
    ovf_d     = ovf_q;
    hinge     = 1'b0;
    cmd.push  = 1'b0;
    cmd.pop3  = 1'b0;
    cmd.clear = 1'b0;
    cmd.entry = '{is_close: is_close, pos: cur_pos};

    if (advance) begin
      if (!ovf_q) begin
        if (pos_q == PCW'(MAX_LENGTH)) begin
          // The counter saturates; a character past the limit is an error.
          ovf_d = 1'b1;
        end else begin
          pos_d = pos_q + PCW'(1);
          if (is_close && view.at_least3 && !view.top2.is_close &&
              !view.top1.is_close && view.top0.is_close) begin
            hinge    = 1'b1;
            cmd.pop3 = 1'b1;
          end else if (is_open || is_close) begin
            if (view.full) begin
              ovf_d = 1'b1;
            end else begin
              cmd.push = 1'b1;
            end
          end
        end
      end
      if (in_item_q.is_last) begin
        cmd.clear = 1'b1;
        pos_d     = '0;
        ovf_d     = 1'b0;
      end
    end
  end

  assign emit = advance && (hinge || in_item_q.is_last);

  always_comb begin
    if (cmd.pop3) begin
      empty_after = view.holds3;
    end else if (cmd.push) begin
      empty_after = 1'b0;
    end else begin
      empty_after = view.is_empty;
    end

    out_item_d = '{
      hinge_found:     1'b0,
      outer_open_pos:  '0,
      inner_open_pos:  '0,
      inner_close_pos: '0,
      outer_close_pos: '0,
      string_done:     1'b0,
      status:          STATUS_OK
    };
    if (hinge) begin
      out_item_d.hinge_found     = 1'b1;
      out_item_d.outer_open_pos  = view.top2.pos;
      out_item_d.inner_open_pos  = view.top1.pos;
      out_item_d.inner_close_pos = view.top0.pos;
      out_item_d.outer_close_pos = cur_pos;
    end
    if (in_item_q.is_last) begin
      out_item_d.string_done = 1'b1;
      // The flag as it stands after this character, before the clear.
      if (ovf_q || (!ovf_q && pos_q == PCW'(MAX_LENGTH)) ||
          (!ovf_q && (is_open || is_close) && !hinge && view.full)) begin
        out_item_d.status = STATUS_OVERFLOW;
      end else if (!empty_after) begin
        out_item_d.status = STATUS_UNBALANCED;
      end
    end

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  bhf_stack #(
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .view_o(view)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      ovf_q       <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
      ovf_q       <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_item_i;
    end
    if (emit) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_no_stack_work_in_error : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> !cmd.push && !cmd.pop3)
    else $error("stack changed while the overflow flag is set");

  a_result_has_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_o && (out_item_o.hinge_found || out_item_o.string_done))
    else $error("result with neither a hinge nor the end of string");

endmodule

/* rtl/core/bhf_ram.sv */
// Generic simple dual-port RAM with a registered read.
module bhf_ram #(
  parameter int unsigned WIDTH = 13,
  parameter int unsigned DEPTH = 342
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/bhf_stack.sv */
// Bracket stack: top three entries in registers, full contents in three RAM banks.
module bhf_stack #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bhf_pkg::stack_cmd_t cmd_i,
  output bhf_pkg::stack_view_t view_o
);
  import bhf_pkg::*;

  localparam int unsigned ROWS = (DEPTH + NUM_BANKS - 1) / NUM_BANKS;
  localparam int unsigned AW   = $clog2(ROWS);
  localparam int unsigned RW   = $clog2(DEPTH / NUM_BANKS + 1);
  localparam int unsigned CW   = $clog2(DEPTH + 1);

  // Entry i lives in bank i mod 3, row i / 3; both are tracked by counters.
  logic [CW-1:0] cnt_q, cnt_d;
  logic [RW-1:0] row_q, row_d;
  logic [1:0]    bank_q, bank_d;
  entry_t        top_q [NUM_BANKS];
  entry_t        top_d [NUM_BANKS];

  logic [AW-1:0] rd_addr [NUM_BANKS];
  entry_t        rd_data [NUM_BANKS];
  logic          wr_en   [NUM_BANKS];

  always_comb begin
    cnt_d  = cnt_q;
    row_d  = row_q;
    bank_d = bank_q;
    top_d  = top_q;
    if (cmd_i.clear) begin
      cnt_d  = '0;
      row_d  = '0;
      bank_d = '0;
    end else if (cmd_i.push) begin
      cnt_d    = cnt_q + CW'(1);
      bank_d   = (bank_q == 2'(NUM_BANKS - 1)) ? 2'd0 : bank_q + 2'd1;
      row_d    = (bank_q == 2'(NUM_BANKS - 1)) ? row_q + RW'(1) : row_q;
      top_d[0] = cmd_i.entry;
      top_d[1] = top_q[0];
      top_d[2] = top_q[1];
    end else if (cmd_i.pop3) begin
      cnt_d = cnt_q - CW'(NUM_BANKS);
      row_d = row_q - RW'(1);
      // The read data holds the three entries just below the cached top.
      case (bank_q)
        2'd0: begin
          top_d[0] = rd_data[2];
          top_d[1] = rd_data[1];
          top_d[2] = rd_data[0];
        end
        2'd1: begin
          top_d[0] = rd_data[0];
          top_d[1] = rd_data[2];
          top_d[2] = rd_data[1];
        end
        default: begin
          top_d[0] = rd_data[1];
          top_d[1] = rd_data[0];
          top_d[2] = rd_data[2];
        end
      endcase
    end
  end

  // Prefetch the entries at next count minus four to six, one per bank.
  always_comb begin
    for (int m = 0; m < NUM_BANKS; m++) begin
      if (2'(m) >= bank_d) begin
        rd_addr[m] = AW'(row_d - RW'(2));
      end else begin
        rd_addr[m] = AW'(row_d - RW'(1));
      end
      wr_en[m] = cmd_i.push && !cmd_i.clear && (bank_q == 2'(m));
    end
  end

  for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
    bhf_ram #(
      .WIDTH($bits(entry_t)),
      .DEPTH(ROWS)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (wr_en[g]),
      .waddr_i(row_q[AW-1:0]),
      .wdata_i(cmd_i.entry),
      .raddr_i(rd_addr[g]),
      .rdata_o(rd_data[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      row_q  <= '0;
      bank_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      row_q  <= row_d;
      bank_q <= bank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
  end

  always_comb begin
    view_o.top0      = top_q[0];
    view_o.top1      = top_q[1];
    view_o.top2      = top_q[2];
    view_o.at_least3 = cnt_q >= CW'(NUM_BANKS);
    view_o.full      = cnt_q == CW'(DEPTH);
    view_o.is_empty  = cnt_q == '0;
    view_o.holds3    = cnt_q == CW'(NUM_BANKS);
  end

  a_row_bank_track : assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_q) == NUM_BANKS * int'(row_q) + int'(bank_q))
    else $error("stack row and bank do not match the count");

  a_no_push_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.push && cmd_i.pop3))
    else $error("push and pop requested together");

  a_pop_needs_three : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop3 && !cmd_i.clear |-> cnt_q >= CW'(NUM_BANKS))
    else $error("pop of three entries with fewer on the stack");

  a_push_not_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push && !cmd_i.clear |-> cnt_q < CW'(DEPTH))
    else $error("push onto a full stack");

endmodule
